// ===== sv/timed_tag_table_macros.svh =====
// Assertion macros shared by the timed tag table RTL.
`ifndef TIMED_TAG_TABLE_MACROS_SVH
`define TIMED_TAG_TABLE_MACROS_SVH

// Same-cycle implication on the rising edge of clk, off during reset.
`define TTT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timed_tag_table: same-cycle property violated");

// Next-cycle implication on the rising edge of clk, off during reset.
`define TTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timed_tag_table: next-cycle property violated");

`endif

// ===== sv/ttt_pkg.sv =====
// Types and constants for the timed tag table.
package ttt_pkg;

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_EXPIRE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  localparam int          PADDR_W       = 3;
  localparam logic        REG_TIMEOUT   = 1'b0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] last_seen;
    logic [31:0] center;
    logic [63:0] corners_low;
    logic [63:0] corners_high;
  } entry_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] tag_id;
    logic [31:0] now_ms;
    logic [31:0] center_xy;
    logic [31:0] corner0_xy;
    logic [31:0] corner1_xy;
    logic [31:0] corner2_xy;
    logic [31:0] corner3_xy;
  } item_t;

  typedef struct packed {
    logic        hit;
    logic        dropped;
    logic [15:0] found_id;
    logic [31:0] found_last_seen;
    logic [31:0] found_center;
    logic [31:0] found_corner0;
    logic [31:0] found_corner1;
    logic [31:0] found_corner2;
    logic [31:0] found_corner3;
    logic [4:0]  entry_count;
    logic [4:0]  removed_count;
  } result_t;

endpackage

// ===== sv/ttt_entry_mem.sv =====
// Entry store: one write port, one registered read port.
module ttt_entry_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  ttt_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output ttt_pkg::entry_t rd_data
);
  import ttt_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/timed_tag_table.sv =====
// Timed tag table: keyed tag store with update, lookup and timeout expiry.
// Flow: an accepted item scans the entries in order, stopping early on an id match
//   (expire scans them all), then the result is registered; mode 3 skips the scan.
// One item at a time: no new item is taken until the result is registered, and the
//   result register waits until the result side has taken the previous result.
// Reset (rst, synchronous): table empty, timeout 1000, no result pending; RAM not cleared.
`include "timed_tag_table_macros.svh"

module timed_tag_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  ttt_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output ttt_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ttt_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ttt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  // Configuration register
  logic [15:0] timeout_lim;

  // Sequencer state
  state_t  state, state_next;
  item_t   item_q;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] issue_idx;   // next entry to read
  logic [CW-1:0] chk_idx;     // entry whose data sits on rd_data
  logic          chk_valid;
  logic [CW-1:0] wr_idx;      // compaction write pointer
  logic [CW-1:0] removed;
  logic          hit_q;
  logic [AW-1:0] hit_idx;
  entry_t        found_q;

  // Entry RAM ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  entry_t        rd_data;

  // Shared compare unit and scan control
  logic          scan_issue;
  logic          id_match;
  logic [31:0]   age;
  logic          expired;
  logic          keep;
  logic          scan_done;
  logic          fin_go;
  entry_t        item_entry;
  result_t       res_next;

  // ---------------------------------------------------------------------------
  // APB configuration port: one register, byte offsets ignored.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_lim <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT) begin
      timeout_lim <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_TIMEOUT) begin
      prdata = {16'd0, timeout_lim};
    end else begin
      prdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Scan datapath: the read of entry i+1 overlaps the check of entry i.
  // ---------------------------------------------------------------------------
  assign item_entry.id           = item_q.tag_id;
  assign item_entry.last_seen    = item_q.now_ms;
  assign item_entry.center       = item_q.center_xy;
  assign item_entry.corners_low  = {item_q.corner1_xy, item_q.corner0_xy};
  assign item_entry.corners_high = {item_q.corner3_xy, item_q.corner2_xy};

  assign scan_issue = (state == S_SCAN) && (issue_idx < count);
  assign id_match   = chk_valid && (item_q.mode != MODE_EXPIRE) &&
                      (rd_data.id == item_q.tag_id);
  // Age wraps modulo 2^32, so a future stamp reads as very old.
  assign age        = item_q.now_ms - rd_data.last_seen;
  assign expired    = age > {16'd0, timeout_lim};
  assign keep       = (state == S_SCAN) && chk_valid &&
                      (item_q.mode == MODE_EXPIRE) && !expired;
  assign scan_done  = (state == S_SCAN) && (id_match || (!chk_valid && !scan_issue));
  assign fin_go     = (state == S_FIN) && (!result_valid || result_ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = (item.mode == MODE_NONE) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and RAM write port
  always_comb begin
    item_ready = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = wr_idx[AW-1:0];
    mem_wdata  = rd_data;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
      end
      S_SCAN: begin
        // Move each survivor down to the compaction pointer.
        mem_we = keep;
      end
      S_FIN: begin
        mem_wdata = item_entry;
        if (fin_go && item_q.mode == MODE_UPDATE) begin
          if (hit_q) begin
            mem_we    = 1'b1;
            mem_waddr = hit_idx;
          end else if (count < FULL) begin
            mem_we    = 1'b1;
            mem_waddr = count[AW-1:0];
          end
        end
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

  // Count after this item
  always_comb begin
    count_next = count;
    unique case (item_q.mode)
      MODE_UPDATE: begin
        if (!hit_q && count < FULL) begin
          count_next = CW'(count + 1'b1);
        end
      end
      MODE_EXPIRE: count_next = wr_idx;
      MODE_LOOKUP: count_next = count;
      MODE_NONE:   count_next = count;
      default:     count_next = count;
    endcase
  end

  // Result assembly
  always_comb begin
    res_next             = '0;
    res_next.entry_count = 5'(count_next);
    unique case (item_q.mode)
      MODE_UPDATE: begin
        res_next.hit     = hit_q;
        res_next.dropped = !hit_q && (count == FULL);
      end
      MODE_EXPIRE: begin
        res_next.removed_count = 5'(removed);
      end
      MODE_LOOKUP: begin
        res_next.hit = hit_q;
        if (hit_q) begin
          res_next.found_id        = found_q.id;
          res_next.found_last_seen = found_q.last_seen;
          res_next.found_center    = found_q.center;
          res_next.found_corner0   = found_q.corners_low[31:0];
          res_next.found_corner1   = found_q.corners_low[63:32];
          res_next.found_corner2   = found_q.corners_high[31:0];
          res_next.found_corner3   = found_q.corners_high[63:32];
        end
      end
      MODE_NONE: begin
        res_next.hit = 1'b0;
      end
      default: begin
        res_next.hit = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      chk_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        chk_valid <= 1'b0;
      end else begin
        chk_valid <= scan_issue;
      end
      if (fin_go) begin
        count        <= count_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q    <= item;
      issue_idx <= '0;
      wr_idx    <= '0;
      removed   <= '0;
      hit_q     <= 1'b0;
    end else if (state == S_SCAN) begin
      if (scan_issue) begin
        issue_idx <= CW'(issue_idx + 1'b1);
        chk_idx   <= issue_idx;
      end
      if (keep) begin
        wr_idx <= CW'(wr_idx + 1'b1);
      end
      if (chk_valid && item_q.mode == MODE_EXPIRE && expired) begin
        removed <= CW'(removed + 1'b1);
      end
      if (id_match) begin
        hit_q   <= 1'b1;
        hit_idx <= chk_idx[AW-1:0];
        found_q <= rd_data;
      end
    end
  end

  // Hold the result until it is taken.
  always_ff @(posedge clk) begin
    if (fin_go) begin
      result <= res_next;
    end
  end

  ttt_entry_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (issue_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TTT_ASSERT_IMPL(a_count_range, 1'b1, count <= FULL)
  `TTT_ASSERT_IMPL(a_hit_xor_drop, result_valid, !(result.hit && result.dropped))
  `TTT_ASSERT_IMPL(a_compact_behind, (state == S_SCAN) && chk_valid, wr_idx <= chk_idx)
  `TTT_ASSERT_NEXT(a_accept_busy, item_valid && item_ready, !item_ready)

endmodule

// ===== tb/tb.sv =====
// Testbench for timed_tag_table: directed and random tag traffic checked against a table model.
module tb;
  import ttt_pkg::*;

  localparam int DEPTH        = 16;
  localparam int POOL         = 20;    // ids in play per random phase; more than the table holds
  localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer before the run is abandoned
  localparam int HOLD_LEN     = 300;   // receiver hold-off used to fill the block
  localparam int DRAIN_CYCLES = 24;    // longer than a full-table scan
  localparam int MAX_REPORTS  = 200;

  localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = PADDR_W'(4 * REG_TIMEOUT);

  logic               clk = 1'b0;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  item_t              item;
  logic               result_valid;
  logic               result_ready;
  result_t            result;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  timed_tag_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tag table model: our own copy of the entries, the count and the timeout.
  // Entries at or above model_count are never read.
  // ---------------------------------------------------------------------------
  logic [15:0]       tag_ids    [DEPTH];
  logic [31:0]       tag_seen   [DEPTH];
  logic [31:0]       tag_center [DEPTH];
  logic [3:0][31:0]  tag_corner [DEPTH];
  int unsigned       model_count;
  logic [15:0]       expiry_ms;

  // Expected results, oldest first; one per accepted item.
  result_t           pending_results[$];

  int                errors = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       hold_asks = 0;
  int unsigned       hold_served = 0;
  int unsigned       hold_left = 0;
  int unsigned       quiet_cycles = 0;

  function automatic int find_tag(logic [15:0] id);
    for (int i = 0; i < model_count; i++)
      if (tag_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic void store_tag(int slot, item_t it);
    tag_ids[slot]    = it.tag_id;
    tag_seen[slot]   = it.now_ms;
    tag_center[slot] = it.center_xy;
    tag_corner[slot] = {it.corner3_xy, it.corner2_xy, it.corner1_xy, it.corner0_xy};
  endfunction

  // Apply one item to the model and return the result the block should produce.
  function automatic result_t track_tags(item_t it);
    result_t     r;
    int          slot;
    int unsigned keep;
    int unsigned gone;
    logic [31:0] age;
    r    = '0;
    gone = 0;
    case (it.mode)
      MODE_UPDATE: begin
        slot = find_tag(it.tag_id);
        if (slot >= 0) begin
          store_tag(slot, it);
          r.hit = 1'b1;
        end else if (model_count < DEPTH) begin
          store_tag(model_count, it);
          model_count++;
        end else begin
          r.dropped = 1'b1;
        end
      end
      MODE_EXPIRE: begin
        // Age wraps modulo 2^32, so a stamp from the future looks very old.
        keep = 0;
        for (int i = 0; i < model_count; i++) begin
          age = it.now_ms - tag_seen[i];
          if (age > {16'd0, expiry_ms}) begin
            gone++;
          end else begin
            tag_ids[keep]    = tag_ids[i];
            tag_seen[keep]   = tag_seen[i];
            tag_center[keep] = tag_center[i];
            tag_corner[keep] = tag_corner[i];
            keep++;
          end
        end
        model_count = keep;
      end
      MODE_LOOKUP: begin
        slot = find_tag(it.tag_id);
        if (slot >= 0) begin
          r.hit             = 1'b1;
          r.found_id        = tag_ids[slot];
          r.found_last_seen = tag_seen[slot];
          r.found_center    = tag_center[slot];
          r.found_corner0   = tag_corner[slot][0];
          r.found_corner1   = tag_corner[slot][1];
          r.found_corner2   = tag_corner[slot][2];
          r.found_corner3   = tag_corner[slot][3];
        end
      end
      default: ;  // unused mode: state untouched, only the count is reported
    endcase
    r.entry_count   = 5'(model_count);
    r.removed_count = 5'(gone);
    return r;
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: mismatch on %s, expected %h, got %h", $time, fname, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready with random stalls, plus a long hold-off on request.
  // Tests ask for a hold-off by bumping hold_asks; count it down here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_asks != hold_served) begin
      hold_served  <= hold_asks;
      hold_left    <= HOLD_LEN;
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check each result transfer against the oldest expectation, field by field.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: mismatch, result with none expected, got %h", $time, result);
      end else begin
        want = pending_results.pop_front();
        check_field("hit", 32'(want.hit), 32'(result.hit));
        check_field("dropped", 32'(want.dropped), 32'(result.dropped));
        check_field("found_id", 32'(want.found_id), 32'(result.found_id));
        check_field("found_last_seen", want.found_last_seen, result.found_last_seen);
        check_field("found_center", want.found_center, result.found_center);
        check_field("found_corner0", want.found_corner0, result.found_corner0);
        check_field("found_corner1", want.found_corner1, result.found_corner1);
        check_field("found_corner2", want.found_corner2, result.found_corner2);
        check_field("found_corner3", want.found_corner3, result.found_corner3);
        check_field("entry_count", 32'(want.entry_count), 32'(result.entry_count));
        check_field("removed_count", 32'(want.removed_count), 32'(result.removed_count));
      end
    end
  end

  // Abandon the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && item_ready) || (result_valid && result_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers. All of them run at the rising edge and drive with NBAs.
  // ---------------------------------------------------------------------------

  // Offer one item, idling first at random; leave valid high after the transfer
  // so a back-to-back item keeps it up without a low blip.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    pending_results.push_back(track_tags(it));
  endtask

  function automatic item_t make_item(mode_t m, logic [15:0] id, logic [31:0] now);
    item_t it;
    it.mode       = m;
    it.tag_id     = id;
    it.now_ms     = now;
    it.center_xy  = $urandom;
    it.corner0_xy = $urandom;
    it.corner1_xy = $urandom;
    it.corner2_xy = $urandom;
    it.corner3_xy = $urandom;
    return it;
  endfunction

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    stall_pct    <= recv_pct;
  endtask

  // Read the timeout register back and compare it with the model's copy.
  task automatic check_timeout_reg;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TIMEOUT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("timeout readback", {16'd0, expiry_ms}, {16'd0, prdata[15:0]});
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write the timeout only once the block has gone quiet.
  task automatic write_timeout(input logic [15:0] value);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // let the last scan wind down before touching the register
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TIMEOUT_ADDR;
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    expiry_ms = value;
    @(posedge clk);
    check_timeout_reg();
  endtask

  // Random traffic over a small pool of ids so the table fills, drops and hits.
  // Time mostly creeps forward at a pace tied to the timeout, with rare jumps.
  task automatic run_tag_traffic(input int n, input logic [31:0] start_ms);
    logic [31:0] now;
    logic [15:0] pool_base;
    logic [15:0] id;
    int unsigned pick;
    now       = start_ms;
    pool_base = 16'($urandom);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 3)
        now = $urandom;
      else
        now += $urandom_range(expiry_ms / 16 + 3);
      if ($urandom_range(9) == 0)
        id = 16'($urandom);
      else
        id = pool_base + 16'($urandom_range(POOL - 1));
      pick = $urandom_range(99);
      if (pick < 50)
        send_item(make_item(MODE_UPDATE, id, now));
      else if (pick < 80)
        send_item(make_item(MODE_LOOKUP, id, now));
      else if (pick < 95)
        send_item(make_item(MODE_EXPIRE, id, now));
      else
        send_item(make_item(MODE_NONE, id, now));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every mode, lookup miss, the exact-timeout boundary,
  // a wrapped stamp and a stamp from the future.
  task automatic test_directed;
    item_t it;
    check_timeout_reg();  // reset value
    send_item(make_item(MODE_LOOKUP, 16'h0000, 32'h0000_0000));
    send_item(make_item(MODE_EXPIRE, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(make_item(MODE_NONE, 16'h5A5A, 32'h0000_1234));
    it = '0;
    it.mode = MODE_UPDATE;
    send_item(it);
    it = '1;
    it.mode = MODE_UPDATE;
    send_item(it);
    // overwrite id 0 with the most negative and most positive coordinates
    it = make_item(MODE_UPDATE, 16'h0000, 32'd5);
    it.center_xy  = 32'h7FFF_8000;
    it.corner0_xy = 32'h8000_7FFF;
    send_item(it);
    send_item(make_item(MODE_LOOKUP, 16'hFFFF, 32'd6));
    send_item(make_item(MODE_LOOKUP, 16'h0000, 32'd6));
    send_item(make_item(MODE_LOOKUP, 16'h1234, 32'd6));
    send_item(make_item(MODE_NONE, 16'h0000, 32'd7));
    // id 0 sits exactly at the timeout and stays; id FFFF wrapped and goes
    send_item(make_item(MODE_EXPIRE, 16'h0000, 32'd1005));
    send_item(make_item(MODE_UPDATE, 16'h0007, 32'd2000));
    // id 7 is stamped in the future, so it looks ancient and goes
    send_item(make_item(MODE_EXPIRE, 16'h0000, 32'd1000));
    send_item(make_item(MODE_LOOKUP, 16'h0007, 32'd1000));
    send_item(make_item(MODE_LOOKUP, 16'h0000, 32'd1000));
  endtask

  // Fill the table, overflow it, hit while full, then expire everything at once.
  task automatic test_full_table;
    logic [15:0] base;
    logic [31:0] t0;
    base = 16'($urandom);
    t0   = $urandom_range(32'h7000_0000, 32'h4000_0000);
    write_timeout(16'hFFFF);
    send_item(make_item(MODE_EXPIRE, base, t0));
    for (int i = 0; i < DEPTH + 2; i++)
      send_item(make_item(MODE_UPDATE, base + 16'(i), t0 + i));
    send_item(make_item(MODE_UPDATE, base, t0 + 40));
    send_item(make_item(MODE_LOOKUP, base + 16'(DEPTH - 1), t0 + 41));
    send_item(make_item(MODE_EXPIRE, base, t0 + 32'd200000));
  endtask

  // Random traffic under each idling pattern, with the timeout swept across
  // its extremes. The last phase starts just short of the time wrap.
  task automatic test_idle_phases;
    set_idling(0, 0);
    write_timeout(16'h0000);
    run_tag_traffic(370, 32'h0000_0000);
    set_idling(71, 0);
    write_timeout(16'hFFFF);
    run_tag_traffic(370, $urandom);
    set_idling(0, 71);
    write_timeout(16'($urandom_range(65534, 1)));
    run_tag_traffic(370, $urandom);
    set_idling(33, 33);
    write_timeout(TIMEOUT_RESET);
    run_tag_traffic(370, 32'hFFFF_F000);
  endtask

  // Hold the result side off while items keep coming, so the input stalls.
  task automatic test_backpressure;
    set_idling(0, 0);
    hold_asks <= hold_asks + 1;
    run_tag_traffic(40, $urandom);
  endtask

  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    model_count = 0;
    expiry_ms   = TIMEOUT_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_table();
    test_idle_phases();
    test_backpressure();

    // drop valid, drain what is still owed, then give the block time to misbehave
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
